>>> rtl/lls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lls_pkg;

   // memory geometry, a power of two, four byte lanes per row
   localparam int MEM_BYTES = 65536;
   localparam int LANES     = 4;
   localparam int MEM_AW    = $clog2(MEM_BYTES);
   localparam int ROWS      = MEM_BYTES / LANES;
   localparam int ROW_W     = $clog2(ROWS);

   // field widths
   localparam int ADDR_W    = 16;
   localparam int DATA_W    = 32;
   localparam int REQ_W     = 56;
   localparam int RSP_W     = 56;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_ISSUE = 2'd1;
   localparam logic [1:0] CMD_TAKE  = 2'd2;

   // latched memory request
   typedef struct packed {
      logic              is_store;
      logic [ADDR_W-1:0] address;
      logic [2:0]        nbytes;
      logic              sign_ext;
      logic [DATA_W-1:0] value;
   } lls_req_type;

   // controller to datapath
   typedef struct packed {
      logic clear_en;
      logic accept;
      logic finish;
      logic out_load;
   } lls_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic completing;
   } lls_stat_type;

endpackage

`default_nettype wire

>>> rtl/latency_load_store_memory_top.sv
// response: an accepted request loads the response register directly; a tick that
//   completes the access goes through a registered byte-lane read, then result capture
// requests: one per cycle unless the response stalls; none in the finish state after a completing tick
// reset: synchronous, active high; afterwards a clearing pass zeroes the
//   memory one four-byte row per cycle with req_tready low
`timescale 1ns / 1ps
`default_nettype none

module latency_load_store_memory_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // access latency register
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [7:0]  csr_data,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // is_store, access_address, byte_count, sign_extend, store_data
   input  wire logic [55:0] req_tdata,
   // command
   input  wire logic [1:0]  req_tuser,
   // response channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // busy_res, ready_res, rejected, result_value, result_address,
   // result_is_store, result_bytes
   output      logic [55:0] rsp_tdata
);

   import lls_pkg::*;

   lls_cmd_type  cmd;
   lls_stat_type stat;

   assign csr_ready = 1'b1;

   lls_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   lls_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_valid          (csr_valid),
      .csr_data           (csr_data),
      .req_command        (req_tuser),
      .req_is_store       (req_tdata[0]),
      .req_access_address (req_tdata[16:1]),
      .req_byte_count     (req_tdata[19:17]),
      .req_sign_extend    (req_tdata[20]),
      .req_store_data     (req_tdata[52:21]),
      .rsp_data           (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> rtl/lls_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/lls_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lls_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lls_pkg::lls_cmd_type        cmd,
   output      lls_pkg::lls_stat_type       stat,
   input  wire logic                        csr_valid,
   input  wire logic [7:0]                  csr_data,
   input  wire logic [1:0]                  req_command,
   input  wire logic                        req_is_store,
   input  wire logic [lls_pkg::ADDR_W-1:0]  req_access_address,
   input  wire logic [2:0]                  req_byte_count,
   input  wire logic                        req_sign_extend,
   input  wire logic [lls_pkg::DATA_W-1:0]  req_store_data,
   output      logic [lls_pkg::RSP_W-1:0]   rsp_data
);

   import lls_pkg::*;

   logic              pend_ff, pend_in;
   logic [7:0]        ticks_ff, ticks_in;
   lls_req_type       pend_req_ff, pend_req_in;
   logic              held_valid_ff, held_valid_in;
   lls_req_type       held_req_ff, held_req_in;
   logic [7:0]        latency_ff;
   logic [ROW_W-1:0]  clr_row_ff;
   logic [RSP_W-1:0]  out_ff, out_in;
   logic              rej;
   logic [2:0]        nbytes_clamped;
   logic [DATA_W-1:0] load_value;

   logic [MEM_AW-1:0] base;
   logic [1:0]        off;
   logic [ROW_W-1:0]  row, row_next;
   logic [7:0]        rd_byte [LANES];
   logic [7:0]        ld_byte [LANES];

   // lane geometry of the pending request
   assign base     = MEM_AW'(pend_req_ff.address);
   assign off      = base[1:0];
   assign row      = base[MEM_AW-1:2];
   assign row_next = row + ROW_W'(1);

   assign stat.completing = (req_command == CMD_TICK) && pend_ff && (ticks_ff == 8'd1);
   assign stat.clear_last = (clr_row_ff == ROW_W'(ROWS - 1));

   // byte lanes: clearing pass, store writes, reads at the pending rows
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [1:0]       byte_idx;
      logic             st_we;
      logic             we;
      logic [ROW_W-1:0] lane_row;
      logic [ROW_W-1:0] waddr;
      logic [7:0]       st_byte;
      logic [7:0]       wdata;

      assign byte_idx = 2'(j) - off;
      assign lane_row = (2'(j) >= off) ? row : row_next;
      assign st_we    = cmd.accept && stat.completing && pend_req_ff.is_store
                        && ({1'b0, byte_idx} < pend_req_ff.nbytes);
      assign st_byte  = 8'(pend_req_ff.value >> {byte_idx, 3'b000});
      assign we       = cmd.clear_en || st_we;
      assign waddr    = cmd.clear_en ? clr_row_ff : lane_row;
      assign wdata    = cmd.clear_en ? 8'h00 : st_byte;

      lls_ram #(
         .WIDTH (8),
         .DEPTH (ROWS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (we),
         .wr_addr (waddr),
         .wr_data (wdata),
         .rd_addr (lane_row),
         .rd_data (rd_byte[j])
      );
   end

   // reorder lanes into bytes and extend
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         ld_byte[i] = rd_byte[off + 2'(i)];
      end
      case (pend_req_ff.nbytes)
         3'd1: begin
            load_value = {{24{pend_req_ff.sign_ext & ld_byte[0][7]}}, ld_byte[0]};
         end
         3'd2: begin
            load_value = {{16{pend_req_ff.sign_ext & ld_byte[1][7]}},
                          ld_byte[1], ld_byte[0]};
         end
         3'd3: begin
            load_value = {{8{pend_req_ff.sign_ext & ld_byte[2][7]}},
                          ld_byte[2], ld_byte[1], ld_byte[0]};
         end
         default: begin
            load_value = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
         end
      endcase
   end

   // byte count clamp
   always_comb begin
      if (req_byte_count == 3'd0) begin
         nbytes_clamped = 3'd1;
      end else if (req_byte_count > 3'd4) begin
         nbytes_clamped = 3'd4;
      end else begin
         nbytes_clamped = req_byte_count;
      end
   end

   // request handling and completion
   always_comb begin
      pend_in       = pend_ff;
      ticks_in      = ticks_ff;
      pend_req_in   = pend_req_ff;
      held_valid_in = held_valid_ff;
      held_req_in   = held_req_ff;
      rej           = 1'b0;
      if (cmd.accept) begin
         case (req_command)
            CMD_TICK: begin
               if (pend_ff) begin
                  ticks_in = ticks_ff - 8'd1;
               end
            end
            CMD_ISSUE: begin
               if (pend_ff) begin
                  rej = 1'b1;
               end else begin
                  pend_req_in.is_store = req_is_store;
                  pend_req_in.address  = req_access_address;
                  pend_req_in.nbytes   = nbytes_clamped;
                  pend_req_in.sign_ext = req_sign_extend;
                  pend_req_in.value    = req_is_store ? req_store_data : '0;
                  ticks_in             = (latency_ff == 8'd0) ? 8'd1 : latency_ff;
                  pend_in              = 1'b1;
               end
            end
            CMD_TAKE: begin
               held_valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
      if (cmd.finish) begin
         held_req_in = pend_req_ff;
         if (!pend_req_ff.is_store) begin
            held_req_in.value = load_value;
         end
         held_valid_in = 1'b1;
         pend_in       = 1'b0;
      end
      out_in = {1'b0, held_req_in.nbytes, held_req_in.is_store, held_req_in.address,
                held_req_in.value, rej, held_valid_in, pend_in};
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         ticks_ff      <= 8'd0;
         held_valid_ff <= 1'b0;
         held_req_ff   <= '0;
         latency_ff    <= 8'd3;
         clr_row_ff    <= '0;
      end else begin
         pend_ff       <= pend_in;
         ticks_ff      <= ticks_in;
         held_valid_ff <= held_valid_in;
         held_req_ff   <= held_req_in;
         if (csr_valid) begin
            latency_ff <= csr_data;
         end
         if (cmd.clear_en) begin
            clr_row_ff <= clr_row_ff + ROW_W'(1);
         end
      end
   end

   // pending request and result payload
   always_ff @(posedge clock) begin
      pend_req_ff <= pend_req_in;
      if (cmd.out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_data = out_ff;

endmodule

`default_nettype wire

>>> rtl/lls_controller.sv
`timescale 1ns / 1ps
`default_nettype none

module lls_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   output      lls_pkg::lls_cmd_type  cmd,
   input  wire lls_pkg::lls_stat_type stat,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready
);

   import lls_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            cmd.accept = req_tvalid && req_tready;
            if (cmd.accept && stat.completing) begin
               state_in = ST_FINISH;
            end else begin
               cmd.out_load = cmd.accept;
            end
         end
         ST_FINISH: begin
            cmd.finish   = 1'b1;
            cmd.out_load = 1'b1;
            state_in     = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/lls_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lls_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);

   // memory clearing keeps requests out right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request accepted during clearing pass");

   // a dropped issue only happens while busy
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2]) |-> rsp_tdata[0])
      else $error("rejected without a pending request");

   // reported byte count never exceeds four
   a_bytes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[54:52] <= 3'd4))
      else $error("result byte count out of range");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind latency_load_store_memory_top lls_checker u_lls_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
